>>> rtl/vbau_pkg.sv
`timescale 1ns / 1ps

package vbau_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_PORT_A = 2'd1,
    KIND_PORT_B = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Analog multiplexer channels (port B bits 2:1)
  typedef enum logic [1:0] {
    CH_Y_HOLD    = 2'd0,
    CH_ZERO_REF  = 2'd1,
    CH_INTENSITY = 2'd2,
    CH_JOY_ONLY  = 2'd3
  } mux_chan_t;

  localparam logic [7:0] DAC_FLIP     = 8'h80;
  localparam logic [7:0] HOLD_MIDDLE  = 8'd128;

  // Finished line segment
  typedef struct packed {
    logic        valid;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [6:0]  intensity;
  } line_t;

  // Clamp a 25-bit signed value to the 24-bit signed range
  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7fffff;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/vbau_beam.sv
`timescale 1ns / 1ps

// Beam integrator and line segment tracker; advances one step per tick.
module vbau_beam import vbau_pkg::*; #(
  parameter int SCREEN_WIDTH  = 33000,
  parameter int SCREEN_HEIGHT = 41000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic [7:0]        port_b,
  input  logic [7:0]        aux_control,
  input  logic              zero_line,
  input  logic              blank_shift,
  input  logic              blank_hand,
  input  logic              timer_ramp,
  input  logic signed [8:0] delta_x,
  input  logic signed [8:0] delta_y,
  input  logic [6:0]        intensity_hold,
  output line_t             line
);

  localparam logic signed [24:0] CENTER_X = 25'(SCREEN_WIDTH / 2);
  localparam logic signed [24:0] CENTER_Y = 25'(SCREEN_HEIGHT / 2);

  function automatic logic on_scr(input logic signed [23:0] bx,
                                  input logic signed [23:0] by);
    return !bx[23] && (bx[22:0] < 23'(SCREEN_WIDTH)) &&
           !by[23] && (by[22:0] < 23'(SCREEN_HEIGHT));
  endfunction

  logic signed [23:0] beam_x, beam_y, beam_x_next, beam_y_next;
  logic               on_now, on_next;
  logic               drawing, drawing_next;
  logic [15:0]        seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic signed [23:0] seg_delta_x, seg_delta_y;
  logic [6:0]         seg_intensity;

  logic               blank, ramp, pull;
  logic signed [8:0]  step_x, step_y;
  logic signed [24:0] pull_x, pull_y, sum_x, sum_y;
  logic signed [23:0] sx, sy;
  logic               emit, open_seg, changed;

  // Per-tick delta and next beam position
  always_comb begin
    blank  = aux_control[4] ? blank_shift : blank_hand;
    ramp   = aux_control[7] ? timer_ramp : port_b[7];
    pull   = !zero_line;
    step_x = ramp ? 9'sd0 : delta_x;
    step_y = ramp ? 9'sd0 : delta_y;
    pull_x = CENTER_X - {beam_x[23], beam_x};
    pull_y = CENTER_Y - {beam_y[23], beam_y};
    sum_x  = {beam_x[23], beam_x} + {{16{step_x[8]}}, step_x};
    sum_y  = {beam_y[23], beam_y} + {{16{step_y[8]}}, step_y};
    if (pull) begin
      // centre pull lands exactly on the centre
      sx          = sat24(pull_x);
      sy          = sat24(pull_y);
      beam_x_next = CENTER_X[23:0];
      beam_y_next = CENTER_Y[23:0];
    end else begin
      sx          = {{15{step_x[8]}}, step_x};
      sy          = {{15{step_y[8]}}, step_y};
      beam_x_next = sat24(sum_x);
      beam_y_next = sat24(sum_y);
    end
    on_next = on_scr(beam_x_next, beam_y_next);
  end

  // Segment open / close decisions
  always_comb begin
    changed      = (sx != seg_delta_x) || (sy != seg_delta_y) ||
                   (intensity_hold != seg_intensity);
    emit         = 1'b0;
    open_seg     = 1'b0;
    drawing_next = drawing;
    if (!drawing) begin
      if (blank && on_now) begin
        drawing_next = 1'b1;
        open_seg     = 1'b1;
      end
    end else if (!blank) begin
      drawing_next = 1'b0;
      emit         = 1'b1;
    end else if (changed) begin
      emit = 1'b1;
      if (on_now) begin
        open_seg = 1'b1;
      end else begin
        drawing_next = 1'b0;
      end
    end
  end

  // Emitted line carries the segment as it stood before this tick
  always_comb begin
    line = '0;
    if (tick && emit) begin
      line.valid     = 1'b1;
      line.x0        = seg_start_x;
      line.y0        = seg_start_y;
      line.x1        = seg_end_x;
      line.y1        = seg_end_y;
      line.intensity = seg_intensity;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_x        <= CENTER_X[23:0];
      beam_y        <= CENTER_Y[23:0];
      on_now        <= 1'b1;
      drawing       <= 1'b0;
      seg_start_x   <= '0;
      seg_start_y   <= '0;
      seg_end_x     <= '0;
      seg_end_y     <= '0;
      seg_delta_x   <= '0;
      seg_delta_y   <= '0;
      seg_intensity <= '0;
    end else if (tick) begin
      beam_x  <= beam_x_next;
      beam_y  <= beam_y_next;
      on_now  <= on_next;
      drawing <= drawing_next;
      if (open_seg) begin
        seg_start_x   <= beam_x[15:0];
        seg_start_y   <= beam_y[15:0];
        seg_delta_x   <= sx;
        seg_delta_y   <= sy;
        seg_intensity <= intensity_hold;
      end
      if (drawing_next && on_next) begin
        seg_end_x <= beam_x_next[15:0];
        seg_end_y <= beam_y_next[15:0];
      end else if (open_seg) begin
        seg_end_x <= beam_x[15:0];
        seg_end_y <= beam_y[15:0];
      end
    end
  end

endmodule

>>> rtl/vector_beam_analog_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  kind, port_a, port_b, aux_control, ...
// result    out        res_valid/res_stall    line_valid, line_x0..line_y1, ...
//
// One item per cycle while item_stall is low; its result appears in the output
// register in the cycle after the transfer. Beam and analog state update in the
// accepting cycle, so the next item follows with no gap. The single output
// register sets the stall: item_stall is high only while a result waits under
// res_stall. Reset initializes holds, beam (to screen center) and segment tracker.
module vector_beam_analog_unit import vbau_pkg::*; #(
  parameter int SCREEN_WIDTH  = 33000,
  parameter int SCREEN_HEIGHT = 41000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  port_a,
  input  logic [7:0]  port_b,
  input  logic [7:0]  aux_control,
  input  logic        zero_line,
  input  logic        blank_shift,
  input  logic        blank_hand,
  input  logic        timer_ramp,
  input  logic [7:0]  joy_chan0,
  input  logic [7:0]  joy_chan1,
  input  logic [7:0]  joy_chan2,
  input  logic [7:0]  joy_chan3,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        line_valid,
  output logic [15:0] line_x0,
  output logic [15:0] line_y0,
  output logic [15:0] line_x1,
  output logic [15:0] line_y1,
  output logic [6:0]  line_intensity,
  output logic        compare_bit
);

  logic              accept, tick, port_wr;
  logic [7:0]        x_hold, y_hold, zero_ref_hold, joy_hold;
  logic [6:0]        intensity_hold;
  logic              compare_flag;
  logic signed [8:0] delta_x, delta_y;
  logic [7:0]        x_next, y_next, zero_next, joy_next;
  logic [6:0]        inten_next;
  logic              demux;
  mux_chan_t         chan;
  line_t             line, line_q;

  assign item_stall = res_valid && res_stall;
  assign accept     = item_valid && !item_stall;
  assign tick       = accept && (kind_t'(kind) == KIND_TICK);
  assign port_wr    = accept && ((kind_t'(kind) == KIND_PORT_A) ||
                                 (kind_t'(kind) == KIND_PORT_B));

  // Sample-and-hold multiplexer for a port write
  always_comb begin
    x_next     = (kind_t'(kind) == KIND_PORT_A) ? (port_a ^ DAC_FLIP) : x_hold;
    y_next     = y_hold;
    zero_next  = zero_ref_hold;
    inten_next = intensity_hold;
    demux      = !port_b[0];
    chan       = mux_chan_t'(port_b[2:1]);
    case (chan)
      CH_Y_HOLD: begin
        joy_next = joy_chan0;
        if (demux) y_next = x_next;
      end
      CH_ZERO_REF: begin
        joy_next = joy_chan1;
        if (demux) zero_next = x_next;
      end
      CH_INTENSITY: begin
        joy_next = joy_chan2;
        if (demux) inten_next = x_next[7] ? x_next[6:0] : 7'd0;
      end
      default: begin
        joy_next = joy_chan3;
      end
    endcase
  end

  // Analog holds, comparator and beam deltas
  always_ff @(posedge clk) begin
    if (rst) begin
      x_hold         <= HOLD_MIDDLE;
      y_hold         <= HOLD_MIDDLE;
      zero_ref_hold  <= HOLD_MIDDLE;
      joy_hold       <= HOLD_MIDDLE;
      intensity_hold <= '0;
      compare_flag   <= 1'b0;
      delta_x        <= '0;
      delta_y        <= '0;
    end else if (port_wr) begin
      x_hold         <= x_next;
      y_hold         <= y_next;
      zero_ref_hold  <= zero_next;
      joy_hold       <= joy_next;
      intensity_hold <= inten_next;
      compare_flag   <= joy_next > x_next;
      delta_x        <= $signed({1'b0, x_next}) - $signed({1'b0, zero_next});
      delta_y        <= $signed({1'b0, zero_next}) - $signed({1'b0, y_next});
    end
  end

  vbau_beam #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_beam (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .port_b         (port_b),
    .aux_control    (aux_control),
    .zero_line      (zero_line),
    .blank_shift    (blank_shift),
    .blank_hand     (blank_hand),
    .timer_ramp     (timer_ramp),
    .delta_x        (delta_x),
    .delta_y        (delta_y),
    .intensity_hold (intensity_hold),
    .line           (line)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_q      <= line;
      compare_bit <= port_wr ? (joy_next > x_next) : compare_flag;
    end
  end

  assign line_valid     = line_q.valid;
  assign line_x0        = line_q.x0;
  assign line_y0        = line_q.y0;
  assign line_x1        = line_q.x1;
  assign line_y1        = line_q.y1;
  assign line_intensity = line_q.intensity;

endmodule
